[design/gubx_pkg.sv]
// Shared types and constants for the GPS binary/text byte parser.
// No dependencies; imported by the top level, the parser core and the result register.
`default_nettype none

package gubx_pkg;

    // Reset value of the largest accepted binary payload length.
    localparam logic [15:0] MAX_LEN_RESET = 16'd85;

    // One parser result word.
    typedef struct packed {
        logic        fix_valid;
        logic        fix_update;
        logic        ack_seen;
        logic        header_done;
        logic [7:0]  frame_class;
        logic [7:0]  frame_id;
        logic [15:0] frame_len;
    } result_t;

endpackage

`default_nettype wire

[design/gps_ubx_nmea_byte_parser_top.sv]
// Top level of the GPS receive-byte parser.
// Depends on gubx_pkg, gubx_in_stage, gubx_parse_core and gubx_out_stage.
//
// Usage:
//   Input channel in_valid/in_ready carries one received GPS byte (rx_byte)
//   per word. Output channel out_valid/out_ready carries exactly one result
//   word per input byte: the fix flag, the fix-update, ack and header-done
//   pulses, and the recorded binary class, id and length.
//   cfg_wr_en/cfg_wr_data write the largest accepted binary payload length;
//   write it only while no byte is in flight.
//   A received byte passes the input register, then the parser logic into
//   the result register, from which its result word is offered.
//   Throughput: one byte per cycle while the receiver does not stall, with
//   the parser state updated between the two registers.
//   Reset: the parser returns to idle, all recorded fields and the fix flag
//   clear, and the length limit returns to 85.
//   Receiver stall: the result register holds its word; the input register
//   still takes one more byte, after which in_ready drops until out_ready.
`default_nettype none

module gps_ubx_nmea_byte_parser_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             fix_valid,
    output logic             fix_update,
    output logic             ack_seen,
    output logic             header_done,
    output logic [7:0]       frame_class,
    output logic [7:0]       frame_id,
    output logic [15:0]      frame_len,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data
);

    import gubx_pkg::*;

    logic        advance;
    logic        step;
    logic [7:0]  byte_q;
    logic [15:0] max_len_reg;
    result_t     core_result;
    result_t     out_result;

    // Length limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_len_reg <= cfg_wr_data;
        end
    end

    gubx_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .advance  (advance),
        .step     (step),
        .byte_q   (byte_q)
    );

    gubx_parse_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .byte_in (byte_q),
        .max_len (max_len_reg),
        .result  (core_result)
    );

    gubx_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step),
        .result_in  (core_result),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (out_result)
    );

    // Break the result word out onto the field ports.
    assign fix_valid   = out_result.fix_valid;
    assign fix_update  = out_result.fix_update;
    assign ack_seen    = out_result.ack_seen;
    assign header_done = out_result.header_done;
    assign frame_class = out_result.frame_class;
    assign frame_id    = out_result.frame_id;
    assign frame_len   = out_result.frame_len;

endmodule

`default_nettype wire

[design/gubx_in_stage.sv]
// Input register: holds one received byte until the parser consumes it.
// Depends on nothing but the downstream advance signal.
`default_nettype none

module gubx_in_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    input  wire logic       advance,
    output logic            step,
    output logic [7:0]      byte_q
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // The stage takes a word when empty or when its word moves on this cycle.
    assign in_ready = !valid_reg || advance;
    assign step     = valid_reg && advance;
    assign byte_q   = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

endmodule

`default_nettype wire

[design/gubx_parse_core.sv]
// Parser state machine: binary header decode and GGA fix sentence scan.
// Depends on gubx_pkg for the result word type.
`default_nettype none

module gubx_parse_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire logic [7:0]      byte_in,
    input  wire logic [15:0]     max_len,
    output gubx_pkg::result_t    result
);

    import gubx_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SYNC2   = 4'd1;
    localparam logic [3:0] ST_CLASS   = 4'd2;
    localparam logic [3:0] ST_ID      = 4'd3;
    localparam logic [3:0] ST_LENLO   = 4'd4;
    localparam logic [3:0] ST_LENHI   = 4'd5;
    localparam logic [3:0] ST_PAYLOAD = 4'd6;
    localparam logic [3:0] ST_TXT_G1  = 4'd7;
    localparam logic [3:0] ST_TXT_P   = 4'd8;
    localparam logic [3:0] ST_TXT_G2  = 4'd9;
    localparam logic [3:0] ST_TXT_G3  = 4'd10;
    localparam logic [3:0] ST_TXT_A   = 4'd11;
    localparam logic [3:0] ST_FIELDS  = 4'd12;

    localparam logic [7:0] SYNC_1    = 8'hb5;
    localparam logic [7:0] SYNC_2    = 8'h62;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] ACK_CLASS = 8'h05;
    localparam logic [2:0] FIX_COMMAS = 3'd6;

    logic [3:0]  state_reg, state_next;
    logic [7:0]  len_lo_reg, len_lo_next;
    logic [7:0]  class_reg, class_next;
    logic [7:0]  id_reg, id_next;
    logic [15:0] len_reg, len_next;
    logic [2:0]  comma_reg, comma_next;
    logic        fix_reg, fix_next;
    logic        upd, ack, hdr;
    logic        class_ok;
    logic [15:0] len_cand;

    // Known binary message classes.
    always_comb
    begin
        case (byte_in)
            8'h01, 8'h02, 8'h04, 8'h05, 8'h06, 8'h09,
            8'h0a, 8'h0b, 8'h0d, 8'h10, 8'h13, 8'h21,
            8'h27, 8'h28: class_ok = 1'b1;
            default:      class_ok = 1'b0;
        endcase
    end

    assign len_cand = {byte_in, len_lo_reg};

    // Next-state and result logic for one byte.
    always_comb
    begin
        state_next  = state_reg;
        len_lo_next = len_lo_reg;
        class_next  = class_reg;
        id_next     = id_reg;
        len_next    = len_reg;
        comma_next  = comma_reg;
        fix_next    = fix_reg;
        upd         = 1'b0;
        ack         = 1'b0;
        hdr         = 1'b0;
        unique case (state_reg)
            ST_SYNC2:
            begin
                state_next = (byte_in == SYNC_2) ? ST_CLASS : ST_IDLE;
            end
            ST_CLASS:
            begin
                class_next = byte_in;
                state_next = class_ok ? ST_ID : ST_IDLE;
            end
            ST_ID:
            begin
                id_next    = byte_in;
                state_next = ST_LENLO;
            end
            ST_LENLO:
            begin
                len_lo_next = byte_in;
                state_next  = ST_LENHI;
            end
            ST_LENHI:
            begin
                len_next = len_cand;
                if ((len_cand == 16'd0) || (len_cand > max_len))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    hdr        = 1'b1;
                    state_next = ST_PAYLOAD;
                end
            end
            ST_PAYLOAD:
            begin
                ack        = (class_reg == ACK_CLASS);
                state_next = ST_IDLE;
            end
            ST_TXT_G1:
            begin
                state_next = (byte_in == CH_G) ? ST_TXT_P : ST_IDLE;
            end
            ST_TXT_P:
            begin
                state_next = (byte_in == CH_P) ? ST_TXT_G2 : ST_IDLE;
            end
            ST_TXT_G2:
            begin
                state_next = (byte_in == CH_G) ? ST_TXT_G3 : ST_IDLE;
            end
            ST_TXT_G3:
            begin
                state_next = (byte_in == CH_G) ? ST_TXT_A : ST_IDLE;
            end
            ST_TXT_A:
            begin
                if (byte_in == CH_A)
                begin
                    comma_next = 3'd0;
                    state_next = ST_FIELDS;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FIELDS:
            begin
                // The byte after the sixth comma is the fix field, whatever it is.
                if (comma_reg == FIX_COMMAS)
                begin
                    fix_next   = (byte_in == CH_ONE) || (byte_in == CH_TWO);
                    upd        = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (byte_in == CH_COMMA)
                begin
                    comma_next = comma_reg + 3'd1;
                end
            end
            default:
            begin
                // Idle, and the unused codes behave as idle.
                if (byte_in == SYNC_1)
                begin
                    state_next = ST_SYNC2;
                end
                else if (byte_in == CH_DOLLAR)
                begin
                    state_next = ST_TXT_G1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Result word reflects the state after this byte.
    always_comb
    begin
        result.fix_valid   = fix_next;
        result.fix_update  = upd;
        result.ack_seen    = ack;
        result.header_done = hdr;
        result.frame_class = class_next;
        result.frame_id    = id_next;
        result.frame_len   = len_next;
    end

    // State advances only when a byte is consumed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            len_lo_reg <= 8'd0;
            class_reg  <= 8'd0;
            id_reg     <= 8'd0;
            len_reg    <= 16'd0;
            comma_reg  <= 3'd0;
            fix_reg    <= 1'b0;
        end
        else if (step)
        begin
            state_reg  <= state_next;
            len_lo_reg <= len_lo_next;
            class_reg  <= class_next;
            id_reg     <= id_next;
            len_reg    <= len_next;
            comma_reg  <= comma_next;
            fix_reg    <= fix_next;
        end
    end

endmodule

`default_nettype wire

[design/gubx_out_stage.sv]
// Result register: holds one parser result word until the receiver takes it.
// Depends on gubx_pkg for the result word type.
`default_nettype none

module gubx_out_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  gubx_pkg::result_t      result_in,
    output logic                   advance,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output gubx_pkg::result_t      result_out
);

    import gubx_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // The register can take a new word when empty or being emptied.
    assign advance    = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign result_out = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result_in;
        end
    end

endmodule

`default_nettype wire

[sim/tb_gps_ubx_nmea_byte_parser_top.sv]
// Self-checking testbench for the GPS binary/text byte parser top level.
// Holds a checking package with the parser predictor and result scoreboard.
// Depends on gubx_pkg and gps_ubx_nmea_byte_parser_top.
`timescale 1ns / 1ps

package gubx_check_pkg;

    import gubx_pkg::*;

    // Parser states as the predictor tracks them.
    typedef enum logic [3:0] {
        PS_IDLE    = 4'd0,
        PS_SYNC2   = 4'd1,
        PS_CLASS   = 4'd2,
        PS_ID      = 4'd3,
        PS_LEN_LO  = 4'd4,
        PS_LEN_HI  = 4'd5,
        PS_PAYLOAD = 4'd6,
        PS_TXT_G1  = 4'd7,
        PS_TXT_P   = 4'd8,
        PS_TXT_G2  = 4'd9,
        PS_TXT_G3  = 4'd10,
        PS_TXT_A   = 4'd11,
        PS_FIELDS  = 4'd12
    } parse_state_e;

    localparam logic [7:0] UBX_SYNC_A = 8'hB5;
    localparam logic [7:0] UBX_SYNC_B = 8'h62;
    localparam logic [7:0] ACK_CLASS  = 8'h05;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_TWO     = 8'h32;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_A       = 8'h41;
    localparam logic [7:0] CH_G       = 8'h47;
    localparam logic [7:0] CH_P       = 8'h50;
    localparam logic [2:0] FIX_COMMA_COUNT = 3'd6;

    // Binary classes that the parser lets through to the id byte.
    localparam logic [7:0] KNOWN_CLASSES [0:13] = '{
        8'h01, 8'h02, 8'h04, 8'h05, 8'h06, 8'h09, 8'h0A,
        8'h0B, 8'h0D, 8'h10, 8'h13, 8'h21, 8'h27, 8'h28
    };

    // Text sentence header, dollar sign first.
    localparam logic [7:0] GGA_HEAD [0:5] = '{CH_DOLLAR, CH_G, CH_P, CH_G, CH_G, CH_A};

    function automatic bit is_known_class(logic [7:0] c);
        foreach (KNOWN_CLASSES[k])
            if (KNOWN_CLASSES[k] == c)
                return 1'b1;
        return 1'b0;
    endfunction

    class ubx_nmea_scoreboard;

        parse_state_e pstate;
        logic [7:0]   len_low;
        logic [7:0]   cls_reg;
        logic [7:0]   id_reg;
        logic [15:0]  len_reg;
        logic [2:0]   commas;
        logic         fix_flag;
        logic [15:0]  max_len;

        result_t      pending[$];
        int           errors;
        int           words_checked;
        int           headers_ok;
        int           acks;
        int           fix_updates;

        function new();
            pstate        = PS_IDLE;
            len_low       = '0;
            cls_reg       = '0;
            id_reg        = '0;
            len_reg       = '0;
            commas        = '0;
            fix_flag      = 1'b0;
            max_len       = MAX_LEN_RESET;
            errors        = 0;
            words_checked = 0;
            headers_ok    = 0;
            acks          = 0;
            fix_updates   = 0;
        endfunction

        function void set_max_len(logic [15:0] v);
            max_len = v;
        endfunction

        // Advance the parser by one accepted byte and queue the word it yields.
        function void note_byte(logic [7:0] b);
            result_t r;
            r = '0;
            case (pstate)
                PS_SYNC2:
                    pstate = (b == UBX_SYNC_B) ? PS_CLASS : PS_IDLE;
                PS_CLASS:
                begin
                    cls_reg = b;
                    pstate  = is_known_class(b) ? PS_ID : PS_IDLE;
                end
                PS_ID:
                begin
                    id_reg = b;
                    pstate = PS_LEN_LO;
                end
                PS_LEN_LO:
                begin
                    len_low = b;
                    pstate  = PS_LEN_HI;
                end
                PS_LEN_HI:
                begin
                    len_reg = {b, len_low};
                    if (len_reg == 16'd0 || len_reg > max_len)
                        pstate = PS_IDLE;
                    else
                    begin
                        r.header_done = 1'b1;
                        pstate        = PS_PAYLOAD;
                    end
                end
                PS_PAYLOAD:
                begin
                    if (cls_reg == ACK_CLASS)
                        r.ack_seen = 1'b1;
                    pstate = PS_IDLE;
                end
                PS_TXT_G1: pstate = (b == CH_G) ? PS_TXT_P : PS_IDLE;
                PS_TXT_P:  pstate = (b == CH_P) ? PS_TXT_G2 : PS_IDLE;
                PS_TXT_G2: pstate = (b == CH_G) ? PS_TXT_G3 : PS_IDLE;
                PS_TXT_G3: pstate = (b == CH_G) ? PS_TXT_A : PS_IDLE;
                PS_TXT_A:
                begin
                    if (b == CH_A)
                    begin
                        commas = '0;
                        pstate = PS_FIELDS;
                    end
                    else
                        pstate = PS_IDLE;
                end
                PS_FIELDS:
                begin
                    // The byte after the sixth comma is the fix field, even a comma.
                    if (commas == FIX_COMMA_COUNT)
                    begin
                        fix_flag     = (b == CH_ONE || b == CH_TWO);
                        r.fix_update = 1'b1;
                        pstate       = PS_IDLE;
                    end
                    else if (b == CH_COMMA)
                        commas = commas + 3'd1;
                end
                default:
                begin
                    if (b == UBX_SYNC_A)
                        pstate = PS_SYNC2;
                    else if (b == CH_DOLLAR)
                        pstate = PS_TXT_G1;
                    else
                        pstate = PS_IDLE;
                end
            endcase
            r.fix_valid   = fix_flag;
            r.frame_class = cls_reg;
            r.frame_id    = id_reg;
            r.frame_len   = len_reg;
            headers_ok  += r.header_done;
            acks        += r.ack_seen;
            fix_updates += r.fix_update;
            pending.push_back(r);
        endfunction

        task report(string what, logic [15:0] got_v, logic [15:0] want_v);
            errors++;
            if (errors <= 40)
                $display("ERROR: word %0d %s: got 0x%0h, expected 0x%0h",
                         words_checked, what, got_v, want_v);
        endtask

        // Compare one result word with the oldest expectation.
        task check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                report("arrived with nothing pending, frame_len", got.frame_len, 16'd0);
                return;
            end
            want = pending.pop_front();
            words_checked++;
            if (got.fix_valid !== want.fix_valid)
                report("fix_valid", 16'(got.fix_valid), 16'(want.fix_valid));
            if (got.fix_update !== want.fix_update)
                report("fix_update", 16'(got.fix_update), 16'(want.fix_update));
            if (got.ack_seen !== want.ack_seen)
                report("ack_seen", 16'(got.ack_seen), 16'(want.ack_seen));
            if (got.header_done !== want.header_done)
                report("header_done", 16'(got.header_done), 16'(want.header_done));
            if (got.frame_class !== want.frame_class)
                report("frame_class", 16'(got.frame_class), 16'(want.frame_class));
            if (got.frame_id !== want.frame_id)
                report("frame_id", 16'(got.frame_id), 16'(want.frame_id));
            if (got.frame_len !== want.frame_len)
                report("frame_len", got.frame_len, want.frame_len);
        endtask

    endclass

endpackage

module tb_gps_ubx_nmea_byte_parser_top;

    import gubx_pkg::*;
    import gubx_check_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          PHASE_BYTES  = 250;
    localparam int          NUM_PHASES   = 6;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic [7:0]  rx_byte     = 8'h00;
    logic        out_ready   = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = 16'h0000;

    logic        in_ready;
    logic        out_valid;
    logic        fix_valid;
    logic        fix_update;
    logic        ack_seen;
    logic        header_done;
    logic [7:0]  frame_class;
    logic [7:0]  frame_id;
    logic [15:0] frame_len;

    ubx_nmea_scoreboard sb;
    bit                 idle_gaps = 1'b1;
    bit                 hold_req  = 1'b0;
    int unsigned        cycle_count = 0;
    int                 bytes_sent  = 0;

    gps_ubx_nmea_byte_parser_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .fix_valid   (fix_valid),
        .fix_update  (fix_update),
        .ack_seen    (ack_seen),
        .header_done (header_done),
        .frame_class (frame_class),
        .frame_id    (frame_id),
        .frame_len   (frame_len),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d words pending",
                     cycle_count, sb.pending.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Idle length: mostly none, some short, a few long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!idle_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Result side: check accepted words, then decide out_ready for the next edge.
    initial
    begin
        int unsigned stall_left;
        int unsigned hold_left;
        result_t     got;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got = '{fix_valid, fix_update, ack_seen, header_done,
                        frame_class, frame_id, frame_len};
                sb.check_result(got);
            end
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready  <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Offer one byte and wait for the handshake; valid stays high afterwards.
    task automatic send_byte(logic [7:0] b);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic stop_input();
        in_valid <= 1'b0;
    endtask

    task automatic send_ubx(logic [7:0] cls, logic [7:0] id, logic [15:0] len,
                            logic [7:0] payload);
        send_byte(UBX_SYNC_A);
        send_byte(UBX_SYNC_B);
        send_byte(cls);
        send_byte(id);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        send_byte(payload);
    endtask

    // Text sentence with six comma-separated fields of random filler.
    task automatic send_gga(logic [7:0] fix_char, int max_fill, bit with_tail);
        logic [7:0] b;
        int         n;
        foreach (GGA_HEAD[k])
            send_byte(GGA_HEAD[k]);
        for (int f = 0; f < 6; f++)
        begin
            send_byte(CH_COMMA);
            n = $urandom_range(0, max_fill);
            for (int k = 0; k < n; k++)
            begin
                b = 8'($urandom_range(0, 255));
                send_byte((b == CH_COMMA) ? CH_ZERO : b);
            end
        end
        send_byte(fix_char);
        if (with_tail)
        begin
            send_byte(CH_COMMA);
            send_byte(CH_STAR);
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // A sentence header cut short and followed by a random byte.
    task automatic send_broken_gga();
        int n;
        n = $urandom_range(1, 5);
        for (int k = 0; k < n; k++)
            send_byte(GGA_HEAD[k]);
        send_byte(8'($urandom_range(0, 255)));
    endtask

    // Wait until every expected word has come back and the pipeline is quiet.
    task automatic drain();
        while (sb.pending.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(logic [15:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_max_len(v);
    endtask

    // Length field: boundaries of the current limit, zero, full range, mostly small.
    function automatic logic [15:0] pick_len(logic [15:0] lim);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 16'd0;
        else if (r < 16)
            return 16'hFFFF;
        else if (r < 24)
            return lim;
        else if (r < 30)
            return lim + 16'd1;
        else if (r < 40)
            return 16'($urandom_range(0, 65535));
        else if (lim == 16'd0)
            return 16'($urandom_range(1, 40));
        else
            return 16'($urandom_range(1, (lim < 16'd64) ? lim : 64));
    endfunction

    function automatic logic [7:0] pick_class();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return ACK_CLASS;
        else if (r < 85)
            return KNOWN_CLASSES[$urandom_range(0, 13)];
        else
            return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_fix_char();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return CH_ONE;
        else if (r < 55)
            return CH_TWO;
        else if (r < 75)
            return CH_ZERO;
        else if (r < 85)
            return CH_COMMA;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // Mostly well-formed frames and sentences with random content, some noise.
    task automatic random_traffic(int target);
        int          start;
        int unsigned r;
        int          n;
        start = bytes_sent;
        while (bytes_sent - start < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                send_ubx(pick_class(), 8'($urandom_range(0, 255)), pick_len(sb.max_len),
                         8'($urandom_range(0, 255)));
            else if (r < 85)
                send_gga(pick_fix_char(), 3, 1'($urandom_range(0, 1)));
            else if (r < 93)
                send_broken_gga();
            else
            begin
                n = $urandom_range(1, 6);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Stimulus and phase sequencing.
    initial
    begin
        logic [15:0] limits [0:NUM_PHASES-1];
        sb = new();
        limits = '{MAX_LEN_RESET, 16'd1, 16'hFFFF, 16'd0,
                   16'($urandom_range(2, 65534)), MAX_LEN_RESET};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: ack frame of length one, rejected class, minimal fix sentence.
        send_ubx(ACK_CLASS, 8'h01, 16'd1, 8'h00);
        send_byte(UBX_SYNC_A);
        send_byte(UBX_SYNC_B);
        send_byte(8'hFF);
        send_gga(CH_ONE, 0, 1'b0);
        send_byte(8'hFF);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p > 0)
            begin
                stop_input();
                write_limit(limits[p]);
            end
            // One phase runs with no idling on either side.
            idle_gaps = (p != 2);
            if (p == 1)
            begin
                // Receiver holds off while bytes keep coming, to fill the block.
                idle_gaps = 1'b0;
                hold_req  = 1'b1;
                repeat (40) send_byte(8'($urandom_range(0, 255)));
                idle_gaps = 1'b1;
            end
            random_traffic(PHASE_BYTES);
        end

        stop_input();
        drain();

        $display("Sent %0d bytes under length limits 85, 1, 65535, 0, %0d and 85.",
                 bytes_sent, limits[4]);
        $display("Checked %0d words: %0d headers accepted, %0d acks, %0d fix updates.",
                 sb.words_checked, sb.headers_ok, sb.acks, sb.fix_updates);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
